@@ src/quadratic_smallest_root_in_range_unit_macros.svh @@
// Assertion macros shared by the checker of the quadratic root unit.
`ifndef QUADRATIC_SMALLEST_ROOT_IN_RANGE_UNIT_MACROS_SVH
`define QUADRATIC_SMALLEST_ROOT_IN_RANGE_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define QSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define QSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked around reset.
`define QSR_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/qsr_pkg.sv @@
// Package of the quadratic root unit: beat types, widths and sideband structs.
package qsr_pkg;

   localparam int WORD_W = 32;
   // The discriminant is below 2^(2*WORD_W+1).
   localparam int DISC_W = 2 * WORD_W + 1;
   localparam int ROOT_W = (DISC_W + 1) / 2;
   // Magnitude of -b -/+ sqrt(disc).
   localparam int NUM_W  = ROOT_W + 1;
   localparam int DIVS_W = WORD_W + 1;

   typedef struct packed {
      logic signed [WORD_W-1:0] coef_a;
      logic signed [WORD_W-1:0] coef_b;
      logic signed [WORD_W-1:0] coef_c;
      logic signed [WORD_W-1:0] t_min;
      logic signed [WORD_W-1:0] t_max;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] root;
      logic                     found;
   } rsp_type;

   typedef struct packed {
      logic                     nope;
      logic                     neg_a;
      logic                     neg_b;
      logic [WORD_W-1:0]        mag_a;
      logic [WORD_W-1:0]        mag_b;
      logic signed [WORD_W-1:0] t_min;
      logic signed [WORD_W-1:0] t_max;
   } sqrt_tag_type;

   typedef struct packed {
      logic                     nope;
      logic                     q_neg;
      logic signed [WORD_W-1:0] t_min;
      logic signed [WORD_W-1:0] t_max;
   } div_tag_type;

endpackage

@@ src/quadratic_smallest_root_in_range_unit.sv @@
// Top level of the quadratic smallest-root-in-interval unit.
//
// Takes a, b, c and an inclusive interval [t_min, t_max] in signed Q16.16 and returns the
// smaller real root of a*t^2 + b*t + c when it lies inside the interval, else -1.0 with
// found low. A zero a or a negative discriminant gives no root. The discriminant is exact,
// the square root is rounded down and the division truncates toward zero. One beat is
// accepted every cycle while no result is held back; each beat passes through the
// 33-stage square root and the (34 + FRAC_BITS)-stage divider.
// The whole pipeline holds while a result waits on rsp_stall.
module quadratic_smallest_root_in_range_unit
   import qsr_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int QW = NUM_W + FRAC_BITS;
   localparam logic [WORD_W-1:0] NONE_ROOT = WORD_W'(0) - (WORD_W'(1) << FRAC_BITS);

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: signs and magnitudes.
   logic                      s1_valid_ff;
   logic                      s1_na_ff, s1_nb_ff, s1_nc_ff, s1_azero_ff;
   logic [WORD_W-1:0]         s1_ma_ff, s1_mb_ff, s1_mc_ff;
   logic signed [WORD_W-1:0]  s1_tmin_ff, s1_tmax_ff;
   logic [WORD_W-1:0]         ma_in, mb_in, mc_in;

   assign ma_in = req_data.coef_a[WORD_W-1] ? WORD_W'(0) - $unsigned(req_data.coef_a)
                                            : $unsigned(req_data.coef_a);
   assign mb_in = req_data.coef_b[WORD_W-1] ? WORD_W'(0) - $unsigned(req_data.coef_b)
                                            : $unsigned(req_data.coef_b);
   assign mc_in = req_data.coef_c[WORD_W-1] ? WORD_W'(0) - $unsigned(req_data.coef_c)
                                            : $unsigned(req_data.coef_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_na_ff    <= req_data.coef_a[WORD_W-1];
         s1_nb_ff    <= req_data.coef_b[WORD_W-1];
         s1_nc_ff    <= req_data.coef_c[WORD_W-1];
         s1_azero_ff <= (req_data.coef_a == '0);
         s1_ma_ff    <= ma_in;
         s1_mb_ff    <= mb_in;
         s1_mc_ff    <= mc_in;
         s1_tmin_ff  <= req_data.t_min;
         s1_tmax_ff  <= req_data.t_max;
      end
   end

   // Stage 2: the two products.
   logic                      s2_valid_ff;
   logic                      s2_na_ff, s2_nb_ff, s2_nc_ff, s2_azero_ff;
   logic [WORD_W-1:0]         s2_ma_ff, s2_mb_ff;
   logic signed [WORD_W-1:0]  s2_tmin_ff, s2_tmax_ff;
   logic [2*WORD_W-1:0]       s2_bb_ff, s2_ac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_na_ff    <= s1_na_ff;
         s2_nb_ff    <= s1_nb_ff;
         s2_nc_ff    <= s1_nc_ff;
         s2_azero_ff <= s1_azero_ff;
         s2_ma_ff    <= s1_ma_ff;
         s2_mb_ff    <= s1_mb_ff;
         s2_tmin_ff  <= s1_tmin_ff;
         s2_tmax_ff  <= s1_tmax_ff;
         s2_bb_ff    <= s1_mb_ff * s1_mb_ff;
         s2_ac_ff    <= s1_ma_ff * s1_mc_ff;
      end
   end

   // Stage 3: the discriminant.
   logic                      s3_valid_ff;
   logic [DISC_W-1:0]         s3_disc_ff;
   sqrt_tag_type              s3_tag_ff;
   logic [2*WORD_W+1:0]       bb_ext, fac, disc_sum, disc_dif;
   logic                      disc_neg;
   logic [DISC_W-1:0]         disc_in;
   sqrt_tag_type              s3_tag_in;

   assign bb_ext   = (2*WORD_W+2)'(s2_bb_ff);
   assign fac      = {s2_ac_ff, 2'b00};
   assign disc_sum = bb_ext + fac;
   assign disc_dif = bb_ext - fac;
   assign disc_neg = (s2_na_ff == s2_nc_ff) && (bb_ext < fac);
   assign disc_in  = (s2_na_ff != s2_nc_ff) ? disc_sum[DISC_W-1:0] : disc_dif[DISC_W-1:0];

   always_comb begin
      s3_tag_in.nope  = s2_azero_ff || disc_neg;
      s3_tag_in.neg_a = s2_na_ff;
      s3_tag_in.neg_b = s2_nb_ff;
      s3_tag_in.mag_a = s2_ma_ff;
      s3_tag_in.mag_b = s2_mb_ff;
      s3_tag_in.t_min = s2_tmin_ff;
      s3_tag_in.t_max = s2_tmax_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_disc_ff <= disc_in;
         s3_tag_ff  <= s3_tag_in;
      end
   end

   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;
   sqrt_tag_type        sq_tag;

   qsr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s3_valid_ff),
      .in_val    (s3_disc_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // Numerator -b -/+ sqrt(disc), split into sign and magnitude.
   logic                      nm_valid_ff;
   logic [NUM_W-1:0]          nm_mag_ff;
   logic [DIVS_W-1:0]         nm_dvs_ff;
   div_tag_type               nm_tag_ff;
   logic signed [NUM_W:0]     b_val, s_val, num;
   logic [NUM_W:0]            num_abs;
   div_tag_type               nm_tag_in;

   assign b_val   = sq_tag.neg_b ? -$signed((NUM_W+1)'(sq_tag.mag_b))
                                 : $signed((NUM_W+1)'(sq_tag.mag_b));
   assign s_val   = $signed((NUM_W+1)'(sq_root));
   assign num     = sq_tag.neg_a ? (s_val - b_val) : (-s_val - b_val);
   assign num_abs = num[NUM_W] ? $unsigned(-num) : $unsigned(num);

   always_comb begin
      nm_tag_in.nope  = sq_tag.nope;
      nm_tag_in.q_neg = num[NUM_W] ^ sq_tag.neg_a;
      nm_tag_in.t_min = sq_tag.t_min;
      nm_tag_in.t_max = sq_tag.t_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (advance) begin
         nm_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nm_mag_ff <= num_abs[NUM_W-1:0];
         nm_dvs_ff <= {sq_tag.mag_a, 1'b0};
         nm_tag_ff <= nm_tag_in;
      end
   end

   logic                dv_valid;
   logic [QW-1:0]       dv_quo;
   div_tag_type         dv_tag;

   qsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (nm_valid_ff),
      .in_num     (nm_mag_ff),
      .in_divisor (nm_dvs_ff),
      .in_tag     (nm_tag_ff),
      .out_valid  (dv_valid),
      .out_quo    (dv_quo),
      .out_tag    (dv_tag)
   );

   // Interval test and result register.
   logic signed [QW:0]  q_val, lo_ext, hi_ext;
   logic                found_in;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   assign q_val    = dv_tag.q_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
   assign lo_ext   = (QW+1)'(dv_tag.t_min);
   assign hi_ext   = (QW+1)'(dv_tag.t_max);
   assign found_in = !dv_tag.nope && (q_val >= lo_ext) && (q_val <= hi_ext);

   always_comb begin
      rsp_in.found = found_in;
      rsp_in.root  = found_in ? $signed(q_val[WORD_W-1:0]) : $signed(NONE_ROOT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/qsr_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
module qsr_sqrt
   import qsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DISC_W-1:0]   in_val,
   input  sqrt_tag_type        in_tag,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output sqrt_tag_type        out_tag
);

   logic                valid_ff [ROOT_W];
   logic [DISC_W-1:0]   rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   sqrt_tag_type        tag_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic                prev_valid;
      logic [DISC_W-1:0]   prev_rem;
      logic [ROOT_W-1:0]   prev_root;
      sqrt_tag_type        prev_tag;
      logic [DISC_W+1:0]   term;
      logic                take;
      logic [DISC_W-1:0]   rem_in;
      logic [ROOT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_val;
         assign prev_root  = '0;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_tag   = tag_ff[k-1];
      end

      // Setting this bit raises root^2 by 2*root*2^B + 2^(2B).
      assign term = ((DISC_W+2)'(prev_root) << (B + 1)) + ((DISC_W+2)'(1) << (2 * B));
      assign take = ((DISC_W+2)'(prev_rem) >= term);
      assign rem_in  = take ? prev_rem - term[DISC_W-1:0] : prev_rem;
      assign root_in = take ? (prev_root | (ROOT_W'(1) << B)) : prev_root;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

@@ src/qsr_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module qsr_div
   import qsr_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [NUM_W-1:0]              in_num,
   input  logic [DIVS_W-1:0]             in_divisor,
   input  div_tag_type                   in_tag,
   output logic                          out_valid,
   output logic [NUM_W+FRAC_BITS-1:0]    out_quo,
   output div_tag_type                   out_tag
);

   localparam int QW = NUM_W + FRAC_BITS;

   logic                valid_ff [QW];
   logic [DIVS_W-1:0]   rem_ff   [QW];
   logic [QW-1:0]       dvd_ff   [QW];
   logic [QW-1:0]       quo_ff   [QW];
   logic [DIVS_W-1:0]   dvs_ff   [QW];
   div_tag_type         tag_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                prev_valid;
      logic [DIVS_W-1:0]   prev_rem;
      logic [QW-1:0]       prev_dvd;
      logic [QW-1:0]       prev_quo;
      logic [DIVS_W-1:0]   prev_dvs;
      div_tag_type         prev_tag;
      logic [DIVS_W:0]     part;
      logic [DIVS_W:0]     diff;
      logic                take;
      logic [DIVS_W-1:0]   rem_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_dvd   = QW'(in_num) << FRAC_BITS;
         assign prev_quo   = '0;
         assign prev_dvs   = in_divisor;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_dvd   = dvd_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_dvs   = dvs_ff[k-1];
         assign prev_tag   = tag_ff[k-1];
      end

      assign part   = {prev_rem, prev_dvd[QW-1]};
      assign diff   = part - {1'b0, prev_dvs};
      assign take   = (part >= {1'b0, prev_dvs});
      assign rem_in = take ? diff[DIVS_W-1:0] : part[DIVS_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dvd_ff[k] <= prev_dvd << 1;
            quo_ff[k] <= {prev_quo[QW-2:0], take};
            dvs_ff[k] <= prev_dvs;
            tag_ff[k] <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

@@ src/qsr_checker.sv @@
// Port-level checker of the quadratic root unit and its bind to the top level.
`include "quadratic_smallest_root_in_range_unit_macros.svh"

module qsr_checker
   import qsr_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam logic [WORD_W-1:0] NONE_ROOT = WORD_W'(0) - (WORD_W'(1) << FRAC_BITS);

   // A result beat that is held back stays valid and unchanged.
   `QSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // The input side only stalls when a result is waiting.
   `QSR_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without a waiting result")

   // A beat without a root carries minus one.
   `QSR_ASSERT_NOW(a_none_value, rsp_valid && !rsp_data.found, rsp_data.root == $signed(NONE_ROOT), "no-root beat has a wrong value")

   // Nothing leaves the block straight after reset.
   `QSR_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind quadratic_smallest_root_in_range_unit qsr_checker #(.FRAC_BITS(FRAC_BITS)) u_qsr_checker (.*);
